>>> design/cdls_pkg.sv
package cdls_pkg;

  localparam int unsigned AddrWidth = 48;

  localparam logic [15:0] FlagLoaded  = 16'h0020;
  localparam logic [15:0] FlagRemoved = 16'h0002;
  localparam logic [15:0] StartHoldMs = 16'd3000;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusPending = 2'd1;

  typedef enum logic [2:0] {
    K_TICK   = 3'd0,
    K_FLAG   = 3'd1,
    K_ADDR   = 3'd2,
    K_LINK   = 3'd3,
    K_LEVEL  = 3'd4,
    K_DISC   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_FETCHING = 3'd1,
    PH_FETCHED  = 3'd2,
    PH_LINKING  = 3'd3,
    PH_LINKED   = 3'd4,
    PH_DONE     = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    LED_HOLD     = 3'd0,
    LED_GO_OFF   = 3'd1,
    LED_GO_ON    = 3'd2,
    LED_START    = 3'd3,
    LED_HOLDING  = 3'd4,
    LED_BLINK    = 3'd5
  } led_mode_e;

  typedef enum logic [2:0] {
    CFG_LEVEL_LOW  = 3'd0,
    CFG_LEVEL_HIGH = 3'd1,
    CFG_TICK_STEP  = 3'd2,
    CFG_FETCH_TO   = 3'd3,
    CFG_LINK_TO    = 3'd4,
    CFG_POLL       = 3'd5,
    CFG_FAST_BLINK = 3'd6,
    CFG_SLOW_BLINK = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  level_low;
    logic [7:0]  level_high;
    logic [9:0]  tick_step_ms;
    logic [15:0] fetch_timeout_ms;
    logic [15:0] link_timeout_ms;
    logic [15:0] poll_period_ms;
    logic [15:0] fast_blink_ms;
    logic [15:0] slow_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] flag_value;
    logic [1:0]  status;
    logic [7:0]  battery_value;
    logic [47:0] device_address;
  } in_t;

  typedef struct packed {
    logic        led_on;
    logic [2:0]  phase;
    logic        start_fetch;
    logic        start_link;
    logic [47:0] target_address;
    logic        ask_level;
    logic        charger_off;
    logic        drop_link;
  } out_t;

endpackage

>>> design/cdls_cfg_regs.sv
module cdls_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output cdls_pkg::cfg_t     cfg_o
);

  cdls_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cdls_pkg::cfg_idx_e'(cfg_idx_i))
        cdls_pkg::CFG_LEVEL_LOW:  cfg_d.level_low        = cfg_wdata_i[7:0];
        cdls_pkg::CFG_LEVEL_HIGH: cfg_d.level_high       = cfg_wdata_i[7:0];
        cdls_pkg::CFG_TICK_STEP:  cfg_d.tick_step_ms     = cfg_wdata_i[9:0];
        cdls_pkg::CFG_FETCH_TO:   cfg_d.fetch_timeout_ms = cfg_wdata_i;
        cdls_pkg::CFG_LINK_TO:    cfg_d.link_timeout_ms  = cfg_wdata_i;
        cdls_pkg::CFG_POLL:       cfg_d.poll_period_ms   = cfg_wdata_i;
        cdls_pkg::CFG_FAST_BLINK: cfg_d.fast_blink_ms    = cfg_wdata_i;
        cdls_pkg::CFG_SLOW_BLINK: cfg_d.slow_blink_ms    = cfg_wdata_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_low        <= 8'd80;
      cfg_q.level_high       <= 8'd85;
      cfg_q.tick_step_ms     <= 10'd50;
      cfg_q.fetch_timeout_ms <= 16'd10000;
      cfg_q.link_timeout_ms  <= 16'd6000;
      cfg_q.poll_period_ms   <= 16'd3000;
      cfg_q.fast_blink_ms    <= 16'd100;
      cfg_q.slow_blink_ms    <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/cdls_step.sv
module cdls_step #(
  parameter int unsigned ADDRESS_BYTES = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  cdls_pkg::in_t   item_i,
  input  cdls_pkg::cfg_t  cfg_i,
  output cdls_pkg::out_t  res_o
);

  localparam int unsigned AddrBits =
      (ADDRESS_BYTES * 8 >= cdls_pkg::AddrWidth) ? cdls_pkg::AddrWidth : ADDRESS_BYTES * 8;
  localparam logic [47:0] AddrMask = {48{1'b1}} >> (cdls_pkg::AddrWidth - AddrBits);

  cdls_pkg::phase_e    phase_q, phase_d;
  cdls_pkg::led_mode_e led_mode_q, led_mode_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] led_elapsed_q, led_elapsed_d;
  logic [15:0] led_period_q, led_period_d;
  logic        led_level_q, led_level_d;
  logic [7:0]  battery_q, battery_d;
  logic        link_up_q, link_up_d;
  logic [47:0] saved_addr_q, saved_addr_d;
  logic [15:0] flag_q, flag_d;

  logic start_fetch, start_link, ask_level, charger_off, drop_link;
  logic in_window;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [9:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {7'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign in_window = (battery_q >= cfg_i.level_low) && (battery_q <= cfg_i.level_high);

  always_comb begin
    phase_d       = phase_q;
    led_mode_d    = led_mode_q;
    elapsed_d     = elapsed_q;
    led_elapsed_d = led_elapsed_q;
    led_period_d  = led_period_q;
    led_level_d   = led_level_q;
    battery_d     = battery_q;
    link_up_d     = link_up_q;
    saved_addr_d  = saved_addr_q;
    flag_d        = flag_q;
    start_fetch   = 1'b0;
    start_link    = 1'b0;
    ask_level     = 1'b0;
    charger_off   = 1'b0;
    drop_link     = 1'b0;

    case (cdls_pkg::kind_e'(item_i.kind))
      cdls_pkg::K_TICK: begin
        // The LED sub-sequencer runs first; the controller may then replace its mode.
        case (led_mode_q)
          cdls_pkg::LED_GO_OFF: begin
            led_level_d = 1'b0;
            led_mode_d  = cdls_pkg::LED_HOLD;
          end
          cdls_pkg::LED_GO_ON: begin
            led_level_d = 1'b1;
            led_mode_d  = cdls_pkg::LED_HOLD;
          end
          cdls_pkg::LED_START: begin
            led_level_d   = 1'b1;
            led_elapsed_d = '0;
            led_period_d  = cdls_pkg::StartHoldMs;
            led_mode_d    = cdls_pkg::LED_HOLDING;
          end
          cdls_pkg::LED_HOLDING: begin
            led_elapsed_d = sat_add(led_elapsed_q, cfg_i.tick_step_ms);
            if (led_elapsed_d >= led_period_q) begin
              led_level_d = 1'b0;
              led_mode_d  = cdls_pkg::LED_HOLD;
            end
          end
          cdls_pkg::LED_BLINK: begin
            led_elapsed_d = sat_add(led_elapsed_q, cfg_i.tick_step_ms);
            if (led_elapsed_d >= led_period_q) begin
              led_elapsed_d = '0;
              led_level_d   = ~led_level_q;
            end
          end
          default: led_mode_d = led_mode_q;
        endcase

        elapsed_d = sat_add(elapsed_q, cfg_i.tick_step_ms);
        case (phase_q)
          cdls_pkg::PH_IDLE: begin
            if (flag_q == cdls_pkg::FlagLoaded) begin
              start_fetch = 1'b1;
              phase_d     = cdls_pkg::PH_FETCHING;
              elapsed_d   = '0;
              led_mode_d  = cdls_pkg::LED_GO_ON;
            end else begin
              led_mode_d  = cdls_pkg::LED_GO_OFF;
            end
          end
          cdls_pkg::PH_FETCHING: begin
            if (elapsed_d > cfg_i.fetch_timeout_ms) phase_d = cdls_pkg::PH_IDLE;
          end
          cdls_pkg::PH_FETCHED: begin
            start_link   = 1'b1;
            elapsed_d    = '0;
            phase_d      = cdls_pkg::PH_LINKING;
            led_mode_d   = cdls_pkg::LED_BLINK;
            led_period_d = cfg_i.fast_blink_ms;
          end
          cdls_pkg::PH_LINKING: begin
            if (elapsed_d > cfg_i.link_timeout_ms) phase_d = cdls_pkg::PH_IDLE;
          end
          cdls_pkg::PH_LINKED: begin
            if (elapsed_d > cfg_i.poll_period_ms) begin
              elapsed_d = '0;
              ask_level = 1'b1;
            end
            if (in_window) begin
              led_mode_d = cdls_pkg::LED_GO_ON;
            end else if (battery_q > cfg_i.level_high) begin
              led_mode_d   = cdls_pkg::LED_BLINK;
              led_period_d = cfg_i.slow_blink_ms;
              charger_off  = 1'b1;
              drop_link    = 1'b1;
              phase_d      = cdls_pkg::PH_DONE;
            end else begin
              led_mode_d   = cdls_pkg::LED_BLINK;
              led_period_d = cfg_i.fast_blink_ms;
            end
            // Removal while linked wins over the level decision.
            if (flag_q == cdls_pkg::FlagRemoved && link_up_q) begin
              drop_link  = 1'b1;
              phase_d    = cdls_pkg::PH_IDLE;
              led_mode_d = cdls_pkg::LED_GO_OFF;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
      cdls_pkg::K_FLAG: flag_d = item_i.flag_value;
      cdls_pkg::K_ADDR: begin
        if (item_i.status == cdls_pkg::StatusOk) begin
          phase_d      = cdls_pkg::PH_FETCHED;
          saved_addr_d = item_i.device_address & AddrMask;
        end else if (item_i.status != cdls_pkg::StatusPending) begin
          phase_d      = cdls_pkg::PH_IDLE;
        end
      end
      cdls_pkg::K_LINK: begin
        if (item_i.status == cdls_pkg::StatusOk) begin
          phase_d   = cdls_pkg::PH_LINKED;
          link_up_d = 1'b1;
        end else begin
          phase_d   = cdls_pkg::PH_IDLE;
        end
      end
      cdls_pkg::K_LEVEL: begin
        if (item_i.status == cdls_pkg::StatusOk) battery_d = item_i.battery_value;
      end
      cdls_pkg::K_DISC: link_up_d = 1'b0;
      default: flag_d = flag_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= cdls_pkg::PH_IDLE;
      led_mode_q    <= cdls_pkg::LED_START;
      elapsed_q     <= '0;
      led_elapsed_q <= '0;
      led_period_q  <= '0;
      led_level_q   <= 1'b0;
      battery_q     <= '0;
      link_up_q     <= 1'b0;
      saved_addr_q  <= '0;
      flag_q        <= '0;
    end else if (adv_i) begin
      phase_q       <= phase_d;
      led_mode_q    <= led_mode_d;
      elapsed_q     <= elapsed_d;
      led_elapsed_q <= led_elapsed_d;
      led_period_q  <= led_period_d;
      led_level_q   <= led_level_d;
      battery_q     <= battery_d;
      link_up_q     <= link_up_d;
      saved_addr_q  <= saved_addr_d;
      flag_q        <= flag_d;
    end
  end

  always_comb begin
    res_o.led_on         = led_level_d;
    res_o.phase          = phase_d;
    res_o.start_fetch    = start_fetch;
    res_o.start_link     = start_link;
    res_o.target_address = saved_addr_d;
    res_o.ask_level      = ask_level;
    res_o.charger_off    = charger_off;
    res_o.drop_link      = drop_link;
  end

endmodule

>>> design/charge_dock_link_sequencer_core.sv
// Charging-dock link sequencer.
// Items arrive on the input channel (in_valid_i / in_ready_o / in_data_i): ticks, charger
// flag updates, address-fetch results, link results, battery replies and disconnect notices.
// Every accepted item yields exactly one result on the output channel (out_valid_o /
// out_ready_i / out_data_o) carrying the LED level, the controller phase, the saved
// address and the request pulses for the charger and the radio.
// An accepted item is held in the input register; when it advances, the controller state
// and the result register are updated together from it. One item per cycle is sustained
// while the receiver does not stall, since each advance updates the controller and LED
// state registers together. When the receiver stalls, the result holds in the output
// register and one more item is taken into the input register; only then does in_ready_o
// drop. Reset empties both registers, puts the controller in idle with the LED in its
// start hold, and loads the configuration defaults. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only while no item is in flight,
// and the block itself does not enforce this.
module charge_dock_link_sequencer_core #(
  parameter int unsigned ADDRESS_BYTES = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cdls_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cdls_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [15:0]     cfg_wdata_i
);

  cdls_pkg::cfg_t cfg;
  cdls_pkg::in_t  item_q;
  cdls_pkg::out_t res, res_q;
  logic           item_vld_q, res_vld_q;
  logic           adv;

  assign adv        = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || adv;

  cdls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cdls_step #(
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) item_vld_q <= in_valid_i;
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_data_i;
    if (adv) res_q <= res;
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

>>> design/cdls_checker.sv
module cdls_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input cdls_pkg::out_t  out_data_o
);

  // Only a stalled output can hold back the input side.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled output");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |->
        $onehot0({out_data_o.start_fetch, out_data_o.start_link, out_data_o.ask_level}))
    else $error("more than one request pulse in a result");

  a_charge_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.charger_off) |->
        (out_data_o.drop_link &&
         (out_data_o.phase == cdls_pkg::PH_DONE || out_data_o.phase == cdls_pkg::PH_IDLE)))
    else $error("charger disabled without disconnect or with wrong phase");

  a_request_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (out_data_o.start_fetch || out_data_o.start_link)) |->
        ((out_data_o.start_fetch && out_data_o.phase == cdls_pkg::PH_FETCHING) ||
         (out_data_o.start_link && out_data_o.phase == cdls_pkg::PH_LINKING)))
    else $error("request pulse does not match the phase");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind charge_dock_link_sequencer_core cdls_checker u_cdls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> test/tb_charge_dock_link_sequencer_core.sv
module tb_charge_dock_link_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cdls_pkg::*;

  localparam int unsigned ADDR_BYTES = 6;
  localparam logic [47:0] ADDR_MASK =
      (ADDR_BYTES * 8 >= 48) ? {48{1'b1}} : ((48'd1 << (ADDR_BYTES * 8)) - 48'd1);

  localparam logic [1:0] STATUS_FAIL     = 2'd2;
  localparam logic [1:0] STATUS_FAIL_ALT = 2'd3;
  localparam logic [2:0] K_RSVD_A        = 3'd6;
  localparam logic [2:0] K_RSVD_B        = 3'd7;

  localparam cfg_t RESET_CFG = '{8'd80, 8'd85, 10'd50, 16'd10000, 16'd6000,
                                 16'd3000, 16'd100, 16'd1000};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;

  charge_dock_link_sequencer_core #(
    .ADDRESS_BYTES(ADDR_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the dock controller, advanced on every input transfer.
  cfg_t        cur_cfg     = RESET_CFG;
  phase_e      ctl_phase   = PH_IDLE;
  logic [15:0] ctl_elapsed = '0;
  led_mode_e   led_mode    = LED_START;
  logic [15:0] led_elapsed = '0;
  logic [15:0] led_period  = '0;
  logic        led_level   = 1'b0;
  logic [7:0]  batt_level  = '0;
  logic        link_up     = 1'b0;
  logic [47:0] saved_addr  = '0;
  logic [15:0] flag_word   = '0;

  out_t expected_results[$];
  out_t oldest_result;
  int   fail_count  = 0;
  int   items_sent  = 0;
  int   stall_left  = 0;
  bit   gaps_on     = 1'b1;

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [9:0] b);
    int unsigned s;
    s = a + b;
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void start_blink(logic [15:0] period);
    led_mode   = LED_BLINK;
    led_period = period;
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t r;
    r = '0;
    case (it.kind)
      K_TICK: begin
        // The LED runs ahead of the controller, so a mode chosen here shows next tick.
        case (led_mode)
          LED_GO_OFF: begin
            led_level = 1'b0;
            led_mode  = LED_HOLD;
          end
          LED_GO_ON: begin
            led_level = 1'b1;
            led_mode  = LED_HOLD;
          end
          LED_START: begin
            led_level   = 1'b1;
            led_elapsed = '0;
            led_period  = StartHoldMs;
            led_mode    = LED_HOLDING;
          end
          LED_HOLDING: begin
            led_elapsed = sat_add(led_elapsed, cur_cfg.tick_step_ms);
            if (led_elapsed >= led_period) begin
              led_level = 1'b0;
              led_mode  = LED_HOLD;
            end
          end
          LED_BLINK: begin
            led_elapsed = sat_add(led_elapsed, cur_cfg.tick_step_ms);
            if (led_elapsed >= led_period) begin
              led_elapsed = '0;
              led_level   = ~led_level;
            end
          end
          default: ;
        endcase
        ctl_elapsed = sat_add(ctl_elapsed, cur_cfg.tick_step_ms);
        case (ctl_phase)
          PH_IDLE: begin
            if (flag_word == FlagLoaded) begin
              r.start_fetch = 1'b1;
              ctl_phase     = PH_FETCHING;
              ctl_elapsed   = '0;
              led_mode      = LED_GO_ON;
            end else begin
              led_mode = LED_GO_OFF;
            end
          end
          PH_FETCHING: if (ctl_elapsed > cur_cfg.fetch_timeout_ms) ctl_phase = PH_IDLE;
          PH_FETCHED: begin
            r.start_link = 1'b1;
            ctl_elapsed  = '0;
            ctl_phase    = PH_LINKING;
            start_blink(cur_cfg.fast_blink_ms);
          end
          PH_LINKING: if (ctl_elapsed > cur_cfg.link_timeout_ms) ctl_phase = PH_IDLE;
          PH_LINKED: begin
            if (ctl_elapsed > cur_cfg.poll_period_ms) begin
              ctl_elapsed = '0;
              r.ask_level = 1'b1;
            end
            if (batt_level >= cur_cfg.level_low && batt_level <= cur_cfg.level_high) begin
              led_mode = LED_GO_ON;
            end else if (batt_level > cur_cfg.level_high) begin
              start_blink(cur_cfg.slow_blink_ms);
              r.charger_off = 1'b1;
              r.drop_link   = 1'b1;
              ctl_phase     = PH_DONE;
            end else begin
              start_blink(cur_cfg.fast_blink_ms);
            end
            // Removal wins over the level decision but keeps its charger_off.
            if (flag_word == FlagRemoved && link_up) begin
              r.drop_link = 1'b1;
              ctl_phase   = PH_IDLE;
              led_mode    = LED_GO_OFF;
            end
          end
          default: ;
        endcase
      end
      K_FLAG: flag_word = it.flag_value;
      K_ADDR: begin
        if (it.status == StatusOk) begin
          ctl_phase  = PH_FETCHED;
          saved_addr = it.device_address & ADDR_MASK;
        end else if (it.status != StatusPending) begin
          ctl_phase = PH_IDLE;
        end
      end
      K_LINK: begin
        if (it.status == StatusOk) begin
          ctl_phase = PH_LINKED;
          link_up   = 1'b1;
        end else begin
          ctl_phase = PH_IDLE;
        end
      end
      K_LEVEL: if (it.status == StatusOk) batt_level = it.battery_value;
      K_DISC:  link_up = 1'b0;
      default: ;
    endcase
    r.led_on         = led_level;
    r.phase          = ctl_phase;
    r.target_address = saved_addr;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [47:0] want, logic [47:0] got);
    $error("%s: expected %0h, got %0h", field, want, got);
    fail_count++;
  endtask

  // Results are checked before the new transfer is predicted; a result never
  // leaves in the same cycle its item is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data_o.led_on !== oldest_result.led_on)
            report_mismatch("led_on", oldest_result.led_on, out_data_o.led_on);
          if (out_data_o.phase !== oldest_result.phase)
            report_mismatch("phase", oldest_result.phase, out_data_o.phase);
          if (out_data_o.start_fetch !== oldest_result.start_fetch)
            report_mismatch("start_fetch", oldest_result.start_fetch, out_data_o.start_fetch);
          if (out_data_o.start_link !== oldest_result.start_link)
            report_mismatch("start_link", oldest_result.start_link, out_data_o.start_link);
          if (out_data_o.target_address !== oldest_result.target_address)
            report_mismatch("target_address", oldest_result.target_address,
                            out_data_o.target_address);
          if (out_data_o.ask_level !== oldest_result.ask_level)
            report_mismatch("ask_level", oldest_result.ask_level, out_data_o.ask_level);
          if (out_data_o.charger_off !== oldest_result.charger_off)
            report_mismatch("charger_off", oldest_result.charger_off, out_data_o.charger_off);
          if (out_data_o.drop_link !== oldest_result.drop_link)
            report_mismatch("drop_link", oldest_result.drop_link, out_data_o.drop_link);
        end
      end
      if (in_valid_i && in_ready_o) expected_results.push_back(predict_result(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEVEL_LOW:  cur_cfg.level_low        = cfg_wdata_i[7:0];
          CFG_LEVEL_HIGH: cur_cfg.level_high       = cfg_wdata_i[7:0];
          CFG_TICK_STEP:  cur_cfg.tick_step_ms     = cfg_wdata_i[9:0];
          CFG_FETCH_TO:   cur_cfg.fetch_timeout_ms = cfg_wdata_i;
          CFG_LINK_TO:    cur_cfg.link_timeout_ms  = cfg_wdata_i;
          CFG_POLL:       cur_cfg.poll_period_ms   = cfg_wdata_i;
          CFG_FAST_BLINK: cur_cfg.fast_blink_ms    = cfg_wdata_i;
          CFG_SLOW_BLINK: cur_cfg.slow_blink_ms    = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls while gaps are enabled.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_ready_i = 1'b0;
      stall_left  = $urandom_range(0, 3);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  function automatic in_t rand_item(logic [2:0] k);
    in_t it;
    it.kind           = k;
    it.flag_value     = 16'($urandom);
    it.status         = 2'($urandom);
    it.battery_value  = 8'($urandom);
    it.device_address = 48'({$urandom, $urandom});
    return it;
  endfunction

  task automatic send_item(in_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_event(logic [2:0] k, logic [1:0] st, logic [47:0] val);
    in_t it;
    it        = rand_item(k);
    it.status = st;
    case (k)
      K_FLAG:  it.flag_value     = val[15:0];
      K_LEVEL: it.battery_value  = val[7:0];
      K_ADDR:  it.device_address = val;
      default: ;
    endcase
    send_item(it);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(rand_item(K_TICK));
  endtask

  function automatic logic [1:0] fail_status();
    return $urandom_range(0, 1) ? STATUS_FAIL : STATUS_FAIL_ALT;
  endfunction

  // Every item returns one result, so an empty queue means the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_settings(cfg_t s);
    cfg_idx_e idx;
    logic [15:0] val;
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_LEVEL_LOW:  val = 16'(s.level_low);
        CFG_LEVEL_HIGH: val = 16'(s.level_high);
        CFG_TICK_STEP:  val = 16'(s.tick_step_ms);
        CFG_FETCH_TO:   val = s.fetch_timeout_ms;
        CFG_LINK_TO:    val = s.link_timeout_ms;
        CFG_POLL:       val = s.poll_period_ms;
        CFG_FAST_BLINK: val = s.fast_blink_ms;
        default:        val = s.slow_blink_ms;
      endcase
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_idx_i   = idx;
      cfg_wdata_i = val;
      @(negedge clk_i);
      cfg_we_i = 1'b0;
    end
  endtask

  // One docking attempt: load flag, address fetch, link, level polling, then an ending.
  task automatic dock_session();
    int pick;
    logic [7:0] lvl;
    pick = $urandom_range(0, 9);
    send_event(K_FLAG, 2'($urandom), (pick < 8) ? 48'(FlagLoaded) : 48'($urandom));
    send_ticks($urandom_range(1, 3));
    pick = $urandom_range(0, 7);
    if (pick == 0) send_event(K_ADDR, StatusPending, 48'({$urandom, $urandom}));
    else if (pick == 1) send_event(K_ADDR, fail_status(), 48'({$urandom, $urandom}));
    else send_event(K_ADDR, StatusOk, 48'({$urandom, $urandom}));
    send_ticks($urandom_range(1, 2));
    pick = $urandom_range(0, 9);
    if (pick == 0) send_event(K_LINK, StatusPending, '0);
    else if (pick == 1) send_event(K_LINK, fail_status(), '0);
    else send_event(K_LINK, StatusOk, '0);
    repeat ($urandom_range(2, 6)) begin
      case ($urandom_range(0, 5))
        0:       lvl = 8'($urandom);
        4:       lvl = 8'($urandom_range(0, cur_cfg.level_low));
        5:       lvl = 8'($urandom_range(cur_cfg.level_high, 255));
        default: lvl = (cur_cfg.level_low <= cur_cfg.level_high) ?
                       8'($urandom_range(cur_cfg.level_low, cur_cfg.level_high)) :
                       8'($urandom);
      endcase
      send_event(K_LEVEL, ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : StatusOk,
                 48'(lvl));
      send_ticks($urandom_range(1, 8));
    end
    case ($urandom_range(0, 3))
      0: begin
        send_event(K_FLAG, 2'($urandom), 48'(FlagRemoved));
        send_ticks(1);
      end
      1: begin
        // Without a live link the removal flag is not acted on.
        send_event(K_DISC, 2'($urandom), '0);
        send_event(K_FLAG, 2'($urandom), 48'(FlagRemoved));
        send_ticks(2);
      end
      2: begin
        send_event(K_LEVEL, StatusOk, 48'd255);
        send_event(K_FLAG, 2'($urandom), 48'(FlagRemoved));
        send_ticks(1);
      end
      default: send_ticks($urandom_range(0, 3));
    endcase
  endtask

  task automatic run_sessions(int n, bit allow_gaps);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_item(rand_item(3'($urandom)));
      else dock_session();
    end
  endtask

  task automatic test_directed_sequence();
    gaps_on = 1'b1;
    send_ticks(2);
    send_event(K_FLAG, StatusOk, 48'hFFFF);
    send_item(rand_item(K_RSVD_B));
    send_event(K_FLAG, StatusOk, 48'(FlagLoaded));
    send_ticks(1);
    send_event(K_ADDR, StatusPending, 48'h1234_5678_9ABC);
    send_event(K_ADDR, StatusOk, {48{1'b1}});
    send_ticks(1);
    send_event(K_LINK, StatusOk, '0);
    send_event(K_LEVEL, StatusOk, 48'd82);
    send_event(K_LEVEL, STATUS_FAIL, 48'd0);
    send_event(K_LEVEL, STATUS_FAIL_ALT, 48'd0);
    send_ticks(1);
    send_event(K_LEVEL, StatusOk, 48'd0);
    send_ticks(1);
    // Battery full and device removed in the same tick.
    send_event(K_LEVEL, StatusOk, 48'd255);
    send_event(K_FLAG, StatusOk, 48'(FlagRemoved));
    send_ticks(1);
    send_item(rand_item(K_RSVD_A));
    send_event(K_LINK, StatusPending, '0);
    send_event(K_ADDR, STATUS_FAIL_ALT, '0);
    send_event(K_ADDR, StatusOk, '0);
    send_event(K_DISC, StatusOk, '0);
    send_event(K_LINK, STATUS_FAIL, '0);
  endtask

  task automatic test_min_settings();
    program_settings('{8'd0, 8'd0, 10'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    run_sessions(40, 1'b1);
  endtask

  task automatic test_zero_step();
    program_settings('{8'($urandom), 8'($urandom), 10'd0, 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 300)), 16'($urandom_range(0, 300))});
    run_sessions(30, 1'b1);
  endtask

  task automatic test_max_settings();
    program_settings('{8'd255, 8'd255, 10'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF});
    // Long tick runs push both counters into saturation.
    send_event(K_FLAG, StatusOk, 48'(FlagLoaded));
    send_ticks(70);
    send_event(K_ADDR, StatusOk, 48'({$urandom, $urandom}));
    send_ticks(1);
    send_event(K_LINK, StatusOk, '0);
    send_event(K_LEVEL, StatusOk, 48'd0);
    send_ticks(70);
    run_sessions(20, 1'b1);
  endtask

  task automatic test_inverted_window();
    program_settings('{8'd200, 8'd50, 10'd50, 16'd400, 16'd300, 16'd150, 16'd100, 16'd250});
    run_sessions(40, 1'b1);
  endtask

  task automatic test_random_settings();
    for (int round = 0; round < 3; round++) begin
      if (round == 1)
        program_settings('{8'($urandom), 8'($urandom), 10'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
      else
        program_settings('{8'($urandom), 8'($urandom), 10'($urandom_range(0, 1023)),
                           16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                           16'($urandom_range(0, 600)), 16'($urandom_range(0, 400)),
                           16'($urandom_range(0, 400))});
      run_sessions(30, 1'b1);
    end
  endtask

  task automatic test_full_rate();
    program_settings(RESET_CFG);
    gaps_on = 1'b0;
    run_sessions(40, 1'b0);
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_sequence();
    test_min_settings();
    test_zero_step();
    test_max_settings();
    test_inverted_window();
    test_random_settings();
    test_full_rate();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
design/cdls_pkg.sv
design/cdls_cfg_regs.sv
design/cdls_step.sv
design/charge_dock_link_sequencer_core.sv
design/cdls_checker.sv
test/tb_charge_dock_link_sequencer_core.sv
